[hdl/k_sorted_stream_sorter_core_macros.svh]
// assertion helpers for the k-sorted stream sorter
`ifndef K_SORTED_STREAM_SORTER_CORE_MACROS_SVH
`define K_SORTED_STREAM_SORTER_CORE_MACROS_SVH

`ifndef SYNTH
// plain property, checked at every edge outside reset
`define KSS_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// implication, antecedent and consequent given apart
`define KSS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
// implication with the consequent checked in the next cycle
`define KSS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define KSS_ASSERT(lbl, clk, rst_n, prop, msg)
`define KSS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define KSS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

[hdl/kss_pkg.sv]
package kss_pkg;

  localparam int DATA_W          = 32;
  localparam int K_W             = 4;
  localparam logic [K_W-1:0] K_RESET = 4'd2;
  localparam int STORE_DEPTH_DEF = 16;

  // per-cycle control broadcast to every cell
  typedef struct packed {
    logic pop;  // shift the chain toward cell 0
    logic ins;  // insert the broadcast value
  } cell_ctrl_t;

endpackage

[hdl/kss_if.sv]
interface kss_in_if;
  import kss_pkg::*;
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] sample_value;
  logic              end_of_sequence;

  modport source (output valid, output sample_value, output end_of_sequence, input ready);
  modport sink (input valid, input sample_value, input end_of_sequence, output ready);
endinterface

interface kss_out_if;
  import kss_pkg::*;
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] sorted_value;
  logic              last_of_sequence;

  modport source (output valid, output sorted_value, output last_of_sequence, input ready);
  modport sink (input valid, input sorted_value, input last_of_sequence, output ready);
endinterface

interface kss_cfg_if;
  import kss_pkg::*;
  logic           valid;
  logic           ready;
  logic [K_W-1:0] window_k;

  modport source (output valid, output window_k, input ready);
  modport sink (input valid, input window_k, output ready);
endinterface

[hdl/k_sorted_stream_sorter_core.sv]
// k-sorted stream sorter
// in_i carries sample_value and end_of_sequence, out_i carries sorted_value and
// last_of_sequence, cfg_i writes window_k (always ready, write only while idle).
// values sit in a row of cells kept in ascending order, cell 0 holds the minimum.
// an input transfer with the row at capacity (window_k+1, at most STORE_DEPTH)
// pops cell 0 into the output register and inserts the new value in the same
// cycle; below capacity the value is only inserted and nothing comes out.
// a result is registered and appears on out_i the cycle after its transfer.
// throughput: one input transfer per cycle while the receiver keeps up; each cell
// does one compare and a neighbor select per cycle.
// end_of_sequence: after that transfer input is held off and the row drains one
// value per cycle while the receiver keeps up, the last one flagged.
// receiver stall: the output register holds its result, input and drain both
// wait until it is taken.
// reset: row empty, window_k = 2; cell contents are not cleared, no sweep.
module k_sorted_stream_sorter_core #(
  parameter int STORE_DEPTH = kss_pkg::STORE_DEPTH_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  kss_in_if.sink    in_i,
  kss_out_if.source out_i,
  kss_cfg_if.sink   cfg_i
);
  import kss_pkg::*;

`include "k_sorted_stream_sorter_core_macros.svh"

  localparam int CntW = $clog2(STORE_DEPTH + 1);
  localparam int CmpW = (CntW > K_W + 1) ? CntW : K_W + 1;

  // sequencer codes
  localparam logic ST_RUN   = 1'b0;
  localparam logic ST_DRAIN = 1'b1;

  logic            state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [CntW-1:0] cnt_s;       // count after an eventual pop
  logic [K_W-1:0]  window_k_q;

  logic              out_valid_q;
  logic [DATA_W-1:0] out_val_q;
  logic              out_last_q;

  logic       out_free, in_xfer, full, pop_in, pop_dr;
  cell_ctrl_t ctrl;

  logic [DATA_W-1:0] cell_val [STORE_DEPTH];
  logic [DATA_W-1:0] cell_s   [STORE_DEPTH];
  logic              cell_lt  [STORE_DEPTH];

  // configuration register
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_k_q <= K_RESET;
    end else if (cfg_i.valid) begin
      window_k_q <= cfg_i.window_k;
    end
  end

  // handshake and pop decisions
  assign out_free   = !out_valid_q || out_i.ready;
  assign in_i.ready = (state_q == ST_RUN) && out_free;
  assign in_xfer    = in_i.valid && in_i.ready;

  // at capacity: count >= min(window_k + 1, STORE_DEPTH)
  assign full = (CmpW'(cnt_q) >= (CmpW'(window_k_q) + CmpW'(1)))
             || (cnt_q == CntW'(STORE_DEPTH));

  assign pop_in   = in_xfer && full;
  assign pop_dr   = (state_q == ST_DRAIN) && out_free && (cnt_q != '0);
  assign ctrl.pop = pop_in || pop_dr;
  assign ctrl.ins = in_xfer;

  assign cnt_s = cnt_q - CntW'(ctrl.pop);
  assign cnt_d = cnt_s + CntW'(ctrl.ins);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_RUN: begin
        if (in_xfer && in_i.end_of_sequence) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (pop_dr && (cnt_q == CntW'(1))) begin
          state_d = ST_RUN;
        end
      end
      default: state_d = ST_RUN;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_RUN;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (ctrl.pop) begin
        out_valid_q <= 1'b1;
      end else if (out_i.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // output register payload, loaded from cell 0 on every pop
  always_ff @(posedge clk_i) begin
    if (ctrl.pop) begin
      out_val_q  <= cell_val[0];
      out_last_q <= pop_dr && (cnt_q == CntW'(1));
    end
  end

  assign out_i.valid            = out_valid_q;
  assign out_i.sorted_value     = out_val_q;
  assign out_i.last_of_sequence = out_last_q;

  // sorted chain, each cell talks to its two neighbors only
  for (genvar i = 0; i < STORE_DEPTH; i++) begin : g_cell
    logic [DATA_W-1:0] right_val;
    logic [DATA_W-1:0] left_s;
    logic              left_lt;

    if (i == STORE_DEPTH - 1) begin : g_tail
      assign right_val = '0;
    end else begin : g_mid
      assign right_val = cell_val[i+1];
    end

    if (i == 0) begin : g_head
      assign left_s  = '0;
      assign left_lt = 1'b0;
    end else begin : g_body
      assign left_s  = cell_s[i-1];
      assign left_lt = cell_lt[i-1];
    end

    kss_cell u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (ctrl),
      .ins_val_i   (in_i.sample_value),
      .occ_i       (CntW'(i) < cnt_s),
      .right_val_i (right_val),
      .left_s_i    (left_s),
      .left_lt_i   (left_lt),
      .val_o       (cell_val[i]),
      .s_o         (cell_s[i]),
      .lt_o        (cell_lt[i])
    );
  end

  // checks
  `KSS_ASSERT(a_cnt_bound, clk_i, rst_ni, cnt_q <= CntW'(STORE_DEPTH), "count beyond store depth")
  `KSS_ASSERT_IMP(a_drain_nonempty, clk_i, rst_ni, state_q == ST_DRAIN, cnt_q != '0, "drain with empty row")
  `KSS_ASSERT_NEXT(a_last_empties, clk_i, rst_ni, pop_dr && (cnt_q == CntW'(1)), (cnt_q == '0) && (state_q == ST_RUN) && out_last_q, "last pop left row busy")
  `KSS_ASSERT_IMP(a_head_sorted, clk_i, rst_ni, cnt_q >= CntW'(2), $signed(cell_val[0]) <= $signed(cell_val[1]), "head cells out of order")

endmodule

[hdl/kss_cell.sv]
module kss_cell (
  input  logic                       clk_i,
  input  kss_pkg::cell_ctrl_t        ctrl_i,
  input  logic [kss_pkg::DATA_W-1:0] ins_val_i,
  input  logic                       occ_i,
  input  logic [kss_pkg::DATA_W-1:0] right_val_i,
  input  logic [kss_pkg::DATA_W-1:0] left_s_i,
  input  logic                       left_lt_i,
  output logic [kss_pkg::DATA_W-1:0] val_o,
  output logic [kss_pkg::DATA_W-1:0] s_o,
  output logic                       lt_o
);
  import kss_pkg::*;

  logic [DATA_W-1:0] val_q, val_d;
  logic [DATA_W-1:0] s;
  logic              lt;

  // value this cell would hold after the shift
  assign s  = ctrl_i.pop ? right_val_i : val_q;
  // empty slots count as plus infinity
  assign lt = !occ_i || ($signed(ins_val_i) < $signed(s));

  always_comb begin
    if (!ctrl_i.ins || !lt) begin
      val_d = s;
    end else if (!left_lt_i) begin
      val_d = ins_val_i;
    end else begin
      val_d = left_s_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.pop || ctrl_i.ins) begin
      val_q <= val_d;
    end
  end

  assign val_o = val_q;
  assign s_o   = s;
  assign lt_o  = lt;

endmodule
